// File: rtl/fbsm_pkg.sv
// ----------------------------------------------------------------------------
// fbsm_pkg: frame buffer slot manager package
// widths, operation and status codes, register indexes and sequencer states
// ----------------------------------------------------------------------------
package fbsm_pkg;

	localparam int SLOT_COUNT = 4;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

	localparam int OP_W     = 2;
	localparam int STAT_W   = 2;
	localparam int PITCH_W  = 18;
	localparam int HEIGHT_W = 16;
	localparam int VSIZE_W  = 32;
	localparam int ADDR_W   = 48;
	localparam int HANDLE_W = 32;
	localparam int OFS_W    = 36;
	localparam int BYTES_W  = 34;
	localparam int ROW_W    = 16;

	// full width of frame bytes times slot index
	localparam int PROD_W    = BYTES_W + IDX_W;
	// shared adder: address width plus a sign bit for the divider compare
	localparam int ALU_W     = ADDR_W + 1;
	localparam int DIV_STEPS = OFS_W;
	localparam int CNT_W     = $clog2(DIV_STEPS + 1);

	localparam int APB_AW    = 5;
	localparam int APB_DW    = 64;
	localparam int REG_IDX_W = 2;

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_FLIP  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_SPACE   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_PITCH_ZERO = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_PITCH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_VSIZE  = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_VBASE  = 2'd3;

	localparam logic [VSIZE_W-1:0] VSIZE_RESET = 32'd16777216;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_FB,
		ST_MUL_OFS,
		ST_END,
		ST_ADDR,
		ST_SEARCH,
		ST_DIV,
		ST_DONE
	} fbsm_state_t;

endpackage

// File: rtl/fbsm_req_if.sv
// ----------------------------------------------------------------------------
// fbsm_req_if: request channel
// valid/ready channel carrying one alloc, free or flip request
// ----------------------------------------------------------------------------
interface fbsm_req_if import fbsm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     operation;
	logic [HANDLE_W-1:0] buffer_id;

	modport source (output valid, output operation, output buffer_id, input ready);
	modport sink (input valid, input operation, input buffer_id, output ready);
endinterface

// File: rtl/fbsm_res_if.sv
// ----------------------------------------------------------------------------
// fbsm_res_if: result channel
// valid/ready channel carrying one result per request
// ----------------------------------------------------------------------------
interface fbsm_res_if import fbsm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STAT_W-1:0]   status;
	logic [HANDLE_W-1:0] new_handle;
	logic [ADDR_W-1:0]   buffer_address;
	logic [OFS_W-1:0]    buffer_offset;
	logic [BYTES_W-1:0]  buffer_bytes;
	logic [ROW_W-1:0]    scan_row;
	logic [HANDLE_W-1:0] shown_handle;
	logic [ADDR_W-1:0]   shown_address;

	modport source (
		output valid, output status, output new_handle, output buffer_address,
		output buffer_offset, output buffer_bytes, output scan_row,
		output shown_handle, output shown_address, input ready
	);
	modport sink (
		input valid, input status, input new_handle, input buffer_address,
		input buffer_offset, input buffer_bytes, input scan_row,
		input shown_handle, input shown_address, output ready
	);
endinterface

// File: rtl/frame_buffer_slot_manager.sv
// ----------------------------------------------------------------------------
// frame_buffer_slot_manager: frame buffer slot table with alloc, free and flip
// one shared adder under a small sequencer does the multiplies, the end-of-
// buffer add, the address add and the scan row division
// ----------------------------------------------------------------------------
// One request is handled at a time and the request channel is ready only
// while the sequencer is idle. An alloc runs a 16-step shift-add for pitch
// times height, an IDX_W-step shift-add for the slot offset, then the end
// add and the address add. A free runs the handle scan, one slot per cycle.
// A flip to a stored handle runs the scan and then a restoring division
// (offset / pitch, one quotient bit a cycle); a flip to handle 0, a flip
// with pitch zero, an alloc with no free slot and an unknown operation go
// straight to the final state. The result sits in an output register, so a
// new request is taken as soon as the sequencer is back in idle, even if the
// previous result has not yet been transferred; the sequencer then waits in
// its final state only if the output register is still occupied.
// Registers sit on an APB port at byte address 8*i (64-bit data) and must be
// written only while the block is idle.
// ----------------------------------------------------------------------------
module frame_buffer_slot_manager import fbsm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	fbsm_req_if.sink          req,
	fbsm_res_if.source        res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// configuration registers
	logic [PITCH_W-1:0]  pitch_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [VSIZE_W-1:0]  vsize_q;
	logic [ADDR_W-1:0]   vbase_q;

	// slot table
	logic [SLOT_COUNT-1:0] slot_used_q;
	logic [HANDLE_W-1:0]   slot_handle_q [SLOT_COUNT];
	logic [OFS_W-1:0]      slot_ofs_q    [SLOT_COUNT];
	logic [ADDR_W-1:0]     slot_addr_q   [SLOT_COUNT];
	logic [BYTES_W-1:0]    slot_bytes_q  [SLOT_COUNT];

	logic [HANDLE_W-1:0] hctr_q;
	logic [HANDLE_W-1:0] shown_q;
	logic [ADDR_W-1:0]   disp_q;

	// sequencer
	fbsm_state_t state_q, state_nxt;
	logic [OP_W-1:0]     op_q;
	logic [HANDLE_W-1:0] id_q;
	logic [IDX_W-1:0]    idx_q;
	logic [CNT_W-1:0]    cnt_q;

	// multiply and divide working registers
	logic [PROD_W-1:0]   acc_q;
	logic [PROD_W-1:0]   mcand_q;
	logic [HEIGHT_W-1:0] mult_q;
	logic [BYTES_W-1:0]  fb_q;
	logic [PROD_W:0]     end_q;
	logic [OFS_W-1:0]    div_q;
	logic [PITCH_W-1:0]  rem_q;
	logic [ROW_W-1:0]    quo_q;

	// result staging
	logic [STAT_W-1:0]   stat_q;
	logic [HANDLE_W-1:0] nh_q;
	logic [ADDR_W-1:0]   baddr_q;
	logic [OFS_W-1:0]    bofs_q;
	logic [BYTES_W-1:0]  bbytes_q;
	logic [ROW_W-1:0]    row_q;

	// output register
	logic                out_valid_q;
	logic [STAT_W-1:0]   out_stat_q;
	logic [HANDLE_W-1:0] out_nh_q;
	logic [ADDR_W-1:0]   out_baddr_q;
	logic [OFS_W-1:0]    out_bofs_q;
	logic [BYTES_W-1:0]  out_bbytes_q;
	logic [ROW_W-1:0]    out_row_q;
	logic [HANDLE_W-1:0] out_shown_q;
	logic [ADDR_W-1:0]   out_disp_q;

	// control and shared unit
	logic               in_ready;
	logic               req_xfer;
	logic               cfg_wr;
	logic [REG_IDX_W-1:0] cfg_idx;
	logic               out_load;
	logic               free_found;
	logic [IDX_W-1:0]   free_idx;
	logic               hit;
	logic               idx_last;
	logic [ALU_W-1:0]   alu_a;
	logic [ALU_W-1:0]   alu_b;
	logic               alu_sub;
	logic [ALU_W-1:0]   alu_sum;
	logic [PROD_W-1:0]  acc_nxt;
	logic [PITCH_W:0]   trial;
	logic               div_ge;
	logic               end_over;

	// ------------------------------------------------------------------
	// apb port: always ready, register i at byte address 8*i
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_idx = paddr[APB_AW-1:APB_AW-REG_IDX_W];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (cfg_idx)
			REG_PITCH:  prdata = APB_DW'(pitch_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_VSIZE:  prdata = APB_DW'(vsize_q);
			REG_VBASE:  prdata = APB_DW'(vbase_q);
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// slot lookups
	// ------------------------------------------------------------------
	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!slot_used_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// handle scan looks at one slot per cycle
	assign hit      = slot_used_q[idx_q] && (slot_handle_q[idx_q] == id_q);
	assign idx_last = (idx_q == IDX_W'(SLOT_COUNT - 1));

	// ------------------------------------------------------------------
	// shared adder / subtractor
	// ------------------------------------------------------------------
	assign trial = {rem_q, div_q[OFS_W-1]};

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			ST_MUL_FB, ST_MUL_OFS: begin
				alu_a = ALU_W'(acc_q);
				alu_b = ALU_W'(mcand_q);
			end
			ST_END: begin
				alu_a = ALU_W'(acc_q);
				alu_b = ALU_W'(fb_q);
			end
			ST_ADDR: begin
				alu_a = ALU_W'(vbase_q);
				alu_b = ALU_W'(acc_q);
			end
			ST_DIV: begin
				alu_a   = ALU_W'(trial);
				alu_b   = ALU_W'(pitch_q);
				alu_sub = 1'b1;
			end
			default: begin
				alu_a = '0;
			end
		endcase
	end

	assign alu_sum  = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);
	// shift-add step: add the multiplicand when the low multiplier bit is set
	assign acc_nxt  = mult_q[0] ? alu_sum[PROD_W-1:0] : acc_q;
	// no borrow out of the trial subtract
	assign div_ge   = !alu_sum[ALU_W-1];
	assign end_over = (end_q > (PROD_W + 1)'(vsize_q));

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					case (req.operation)
						OP_ALLOC: state_nxt = free_found ? ST_MUL_FB : ST_DONE;
						OP_FREE:  state_nxt = ST_SEARCH;
						OP_FLIP: begin
							if (pitch_q == '0 || req.buffer_id == '0) state_nxt = ST_DONE;
							else state_nxt = ST_SEARCH;
						end
						default:  state_nxt = ST_DONE;
					endcase
				end
			end
			ST_MUL_FB: begin
				if (cnt_q == CNT_W'(HEIGHT_W - 1)) state_nxt = ST_MUL_OFS;
			end
			ST_MUL_OFS: begin
				if (cnt_q == CNT_W'(IDX_W - 1)) state_nxt = ST_END;
			end
			ST_END:  state_nxt = ST_ADDR;
			ST_ADDR: state_nxt = ST_DONE;
			ST_SEARCH: begin
				if (hit) state_nxt = (op_q == OP_FLIP) ? ST_DIV : ST_DONE;
				else if (idx_last) state_nxt = ST_DONE;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || res.ready) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		out_load = (state_q == ST_DONE) && (!out_valid_q || res.ready);
	end

	assign req.ready = in_ready;
	assign req_xfer  = req.valid && in_ready;

	// ------------------------------------------------------------------
	// control state, config and slot status
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pitch_q     <= '0;
			height_q    <= '0;
			vsize_q     <= VSIZE_RESET;
			vbase_q     <= '0;
			slot_used_q <= '0;
			hctr_q      <= HANDLE_W'(1);
			shown_q     <= '0;
			disp_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;

			if (cfg_wr) begin
				case (cfg_idx)
					REG_PITCH:  pitch_q  <= pwdata[PITCH_W-1:0];
					REG_HEIGHT: height_q <= pwdata[HEIGHT_W-1:0];
					REG_VSIZE:  vsize_q  <= pwdata[VSIZE_W-1:0];
					REG_VBASE:  vbase_q  <= pwdata[ADDR_W-1:0];
					default:    pitch_q  <= pitch_q;
				endcase
			end

			// flip to handle 0 shows the front buffer
			if (req_xfer && req.operation == OP_FLIP && pitch_q != '0
					&& req.buffer_id == '0) begin
				shown_q <= '0;
				disp_q  <= vbase_q;
			end

			if (state_q == ST_ADDR && !end_over) begin
				slot_used_q[idx_q] <= 1'b1;
				hctr_q             <= hctr_q + HANDLE_W'(1);
			end

			if (state_q == ST_SEARCH && hit && op_q == OP_FREE) begin
				slot_used_q[idx_q] <= 1'b0;
			end

			if (state_q == ST_DIV && cnt_q == CNT_W'(DIV_STEPS - 1)) begin
				shown_q <= id_q;
				disp_q  <= slot_addr_q[idx_q];
			end

			if (out_load) out_valid_q <= 1'b1;
			else if (res.ready) out_valid_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// datapath
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_xfer) begin
					op_q     <= req.operation;
					id_q     <= req.buffer_id;
					cnt_q    <= '0;
					idx_q    <= (req.operation == OP_ALLOC) ? free_idx : '0;
					acc_q    <= '0;
					mcand_q  <= PROD_W'(pitch_q);
					mult_q   <= height_q;
					nh_q     <= '0;
					baddr_q  <= '0;
					bofs_q   <= '0;
					bbytes_q <= '0;
					row_q    <= '0;
					case (req.operation)
						OP_ALLOC: stat_q <= free_found ? STAT_OK : STAT_NO_SPACE;
						OP_FREE:  stat_q <= STAT_OK;
						OP_FLIP:  stat_q <= (pitch_q == '0) ? STAT_PITCH_ZERO : STAT_OK;
						default:  stat_q <= STAT_NO_SPACE;
					endcase
				end
			end
			ST_MUL_FB: begin
				cnt_q   <= cnt_q + CNT_W'(1);
				acc_q   <= acc_nxt;
				mcand_q <= mcand_q << 1;
				mult_q  <= mult_q >> 1;
				if (cnt_q == CNT_W'(HEIGHT_W - 1)) begin
					// frame bytes done, set up frame bytes times slot index
					fb_q    <= acc_nxt[BYTES_W-1:0];
					acc_q   <= '0;
					mcand_q <= acc_nxt;
					mult_q  <= HEIGHT_W'(idx_q);
					cnt_q   <= '0;
				end
			end
			ST_MUL_OFS: begin
				cnt_q   <= cnt_q + CNT_W'(1);
				acc_q   <= acc_nxt;
				mcand_q <= mcand_q << 1;
				mult_q  <= mult_q >> 1;
			end
			ST_END: begin
				end_q <= alu_sum[PROD_W:0];
			end
			ST_ADDR: begin
				if (end_over) begin
					stat_q <= STAT_NO_SPACE;
				end else begin
					slot_handle_q[idx_q] <= hctr_q;
					slot_ofs_q[idx_q]    <= acc_q[OFS_W-1:0];
					slot_addr_q[idx_q]   <= alu_sum[ADDR_W-1:0];
					slot_bytes_q[idx_q]  <= fb_q;
					nh_q                 <= hctr_q;
					baddr_q              <= alu_sum[ADDR_W-1:0];
					bofs_q               <= acc_q[OFS_W-1:0];
					bbytes_q             <= fb_q;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					div_q <= slot_ofs_q[idx_q];
					rem_q <= '0;
					quo_q <= '0;
					cnt_q <= '0;
				end else if (idx_last) begin
					stat_q <= STAT_NOT_FOUND;
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			ST_DIV: begin
				// restoring division, only the low quotient bits are kept
				cnt_q <= cnt_q + CNT_W'(1);
				div_q <= div_q << 1;
				rem_q <= div_ge ? alu_sum[PITCH_W-1:0] : trial[PITCH_W-1:0];
				quo_q <= {quo_q[ROW_W-2:0], div_ge};
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) row_q <= {quo_q[ROW_W-2:0], div_ge};
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase

		if (out_load) begin
			out_stat_q   <= stat_q;
			out_nh_q     <= nh_q;
			out_baddr_q  <= baddr_q;
			out_bofs_q   <= bofs_q;
			out_bbytes_q <= bbytes_q;
			out_row_q    <= row_q;
			out_shown_q  <= shown_q;
			out_disp_q   <= disp_q;
		end
	end

	// result channel
	assign res.valid          = out_valid_q;
	assign res.status         = out_stat_q;
	assign res.new_handle     = out_nh_q;
	assign res.buffer_address = out_baddr_q;
	assign res.buffer_offset  = out_bofs_q;
	assign res.buffer_bytes   = out_bbytes_q;
	assign res.scan_row       = out_row_q;
	assign res.shown_handle   = out_shown_q;
	assign res.shown_address  = out_disp_q;

endmodule
